/* rtl/bagauge_pkg.sv */
// ----------------------------------------------------------------------------
// bagauge_pkg
// Shared widths, register indexes and constants for the battery gauge.
// ----------------------------------------------------------------------------
package bagauge_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned VOLT_W       = 8;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned TICK_W       = 8;
  localparam int unsigned WINDOW_W     = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam int unsigned SUM_W        = 28;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned ELAPSED_W    = 17;
  localparam int unsigned ACC_SMP_W    = 16;

  localparam int unsigned DIV_W        = 28;
  localparam int unsigned DVS_W        = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;

  localparam logic [VOLT_W-1:0]   FULL_SCALE_RST = 8'd255;
  localparam logic [TICK_W-1:0]   TICK_RST       = 8'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_RST     = 16'd1000;

  localparam logic [DIV_W-1:0] PCT_SCALE      = 28'd100;
  localparam logic [DIV_W-1:0] PCT_FULL_LIMIT = 28'd98;
  localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;

endpackage

/* rtl/bagauge_if.sv */
// ----------------------------------------------------------------------------
// bagauge_if
// Valid/ready channels of the battery gauge: sample, result and config write.
// ----------------------------------------------------------------------------
interface bagauge_in_if import bagauge_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bagauge_out_if import bagauge_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] battery_voltage;
  logic [PCT_W-1:0]  charge_percent;

  modport source (output valid, output battery_voltage, output charge_percent, input ready);
  modport sink   (input valid, input battery_voltage, input charge_percent, output ready);
endinterface

interface bagauge_cfg_if import bagauge_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/battery_adc_window_average_gauge.sv */
// ----------------------------------------------------------------------------
// battery_adc_window_average_gauge
// Boxcar average of battery ADC samples, reported as voltage and charge.
// ----------------------------------------------------------------------------
// Each accepted sample is summed, counted and advances elapsed time by the
// tick period; the block is ready again on the next cycle. The
// sample that closes the window starts the report sequence: sum/count and
// voltage*100/full_scale each run through one shared 28-step serial divider,
// with one multiply between them, so no new sample is taken until the result
// is loaded into the output register, which waits while an earlier result
// still sits there. The result sits in an output register, so a stalled result
// does not hold up new samples until another window closes.
// Config writes are always taken and should be made only while idle.
module battery_adc_window_average_gauge import bagauge_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bagauge_cfg_if.sink   cfg_i,
  bagauge_in_if.sink    in_i,
  bagauge_out_if.source out_o
);

  localparam logic [ACC_SMP_W-1:0] SampleMask = ACC_SMP_W'((32'd1 << ADC_BITS) - 1);
  localparam int unsigned ProdW = DIV_W + VOLT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AVG  = 3'd1;
  localparam logic [2:0] ST_PCT  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  logic [VOLT_W-1:0]   fsv_q;
  logic [TICK_W-1:0]   tick_q;
  logic [WINDOW_W-1:0] win_q;

  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ELAPSED_W-1:0] el_q, el_d;

  logic [ACC_SMP_W-1:0] sample;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic [CNT_W-1:0]     cnt_sat;
  logic [ELAPSED_W:0]   el_add;
  logic [ELAPSED_W-1:0] el_sat;
  logic                 win_hit;
  logic                 in_acc;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  logic [ProdW-1:0]  prod_q;
  logic [VOLT_W-1:0] volt;
  logic [VOLT_W-1:0] volt_q;
  logic [PCT_W-1:0]  pct_calc;
  logic [PCT_W-1:0]  pct_q;

  logic              out_valid_q, out_valid_d;
  logic [VOLT_W-1:0] out_volt_q;
  logic [PCT_W-1:0]  out_pct_q;
  logic              out_load;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsv_q  <= FULL_SCALE_RST;
      tick_q <= TICK_RST;
      win_q  <= WINDOW_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FULL_SCALE: fsv_q  <= cfg_i.data[VOLT_W-1:0];
        CFG_TICK:       tick_q <= cfg_i.data[TICK_W-1:0];
        CFG_WINDOW:     win_q  <= cfg_i.data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulators
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    sample  = ACC_SMP_W'(in_i.adc_sample) & SampleMask;
    sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sample);
    sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    cnt_sat = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    el_add  = {1'b0, el_q} + (ELAPSED_W + 1)'(tick_q);
    el_sat  = el_add[ELAPSED_W] ? '1 : el_add[ELAPSED_W-1:0];
    win_hit = el_sat >= ELAPSED_W'(win_q);
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    el_d  = el_q;
    if (in_acc) begin
      if (win_hit) begin
        sum_d = '0;
        cnt_d = '0;
        el_d  = '0;
      end else begin
        sum_d = sum_sat;
        cnt_d = cnt_sat;
        el_d  = el_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      el_q  <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      el_q  <= el_d;
    end
  end

  // shared divider
  assign volt = prod_q[ADC_BITS +: VOLT_W];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(sum_sat);
    div_divisor  = DVS_W'(cnt_sat);
    if (state_q == ST_IDLE) begin
      div_start = in_acc && win_hit;
    end else if (state_q == ST_PCT) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(volt) * PCT_SCALE;
      div_divisor  = DVS_W'(fsv_q);
    end
  end

  bagauge_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    if (fsv_q == '0) begin
      pct_calc = '0;
    end else if (div_quot >= PCT_FULL_LIMIT) begin
      pct_calc = PCT_FULL;
    end else begin
      pct_calc = div_quot[PCT_W-1:0];
    end
  end

  // sequencer
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && win_hit) state_d = ST_AVG;
      ST_AVG:  if (div_done) state_d = ST_PCT;
      ST_PCT:  state_d = ST_WAIT;
      ST_WAIT: if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_AVG && div_done) begin
      prod_q <= ProdW'(div_quot) * ProdW'(fsv_q);
    end
    if (state_q == ST_PCT) begin
      volt_q <= volt;
    end
    if (state_q == ST_WAIT && div_done) begin
      pct_q <= pct_calc;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_volt_q <= volt_q;
      out_pct_q  <= pct_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.battery_voltage = out_volt_q;
  assign out_o.charge_percent  = out_pct_q;

endmodule

/* rtl/bagauge_div.sv */
// ----------------------------------------------------------------------------
// bagauge_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bagauge_div import bagauge_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIV_W);
  localparam logic [CntW-1:0] LastStep = CntW'(DIV_W - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_d   = {quo_q[DIV_W-2:0], ge};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/bagauge_chk.sv */
// ----------------------------------------------------------------------------
// bagauge_chk
// Port-level checks for the battery gauge, bound to the top level.
// ----------------------------------------------------------------------------
module bagauge_chk import bagauge_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [VOLT_W-1:0] volt_i,
  input logic [PCT_W-1:0]  pct_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(volt_i) && $stable(pct_i))
    else $error("result word dropped or changed while stalled");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pct_i <= 7'd97) || (pct_i == PCT_FULL))
    else $error("charge percent out of range");

  a_zero_volt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (volt_i == '0) |-> (pct_i == '0))
    else $error("nonzero percent at zero voltage");

  a_rose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a report sequence");

  a_in_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input stalled without an accepted sample");

endmodule

bind battery_adc_window_average_gauge bagauge_chk u_bagauge_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .volt_i      (out_o.battery_voltage),
  .pct_i       (out_o.charge_percent)
);
